/* rtl/teq_pkg.sv */
// teq_pkg: shared types and fixed constants of the timed event queue
// used by teq_ctrl, teq_datapath and timed_event_queue; no dependencies
`default_nettype none

package teq_pkg;

    localparam int TICK_W     = 32;     // tick count and due tick width
    localparam int DELAY_W    = 32;     // start delay, unsigned q16.16 seconds
    localparam int FRAC_W     = 16;     // fraction bits of the start delay
    localparam int RATE_W     = 20;     // control rate register width
    localparam int PORT_ID_W  = 8;      // event id width on the ports
    localparam int OCC_W      = 5;      // occupancy width on the result port
    localparam int PROD_W     = DELAY_W + RATE_W;
    localparam int TICKS_W    = PROD_W - FRAC_W;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(4410);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MUL    = 4'b0010,
        S_SUM    = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic mul_en;    // register delay times rate
        logic sum_en;    // register the saturated due tick
        logic commit;    // update the queue and load the result register
    } cmd_t;

    typedef struct packed {
        logic is_insert; // captured transaction is an insert
    } status_t;

endpackage

`default_nettype wire

/* rtl/teq_ctrl.sv */
// teq_ctrl: sequencing state machine of the timed event queue
// uses teq_pkg; drives teq_datapath through cmd_t and reads status_t
`default_nettype none

module teq_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire              m_ready,
    input  teq_pkg::status_t status,
    output teq_pkg::cmd_t    cmd
);

    teq_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == teq_pkg::S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            teq_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = teq_pkg::S_MUL;
                end
            end
            teq_pkg::S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = status.is_insert ? teq_pkg::S_SUM : teq_pkg::S_COMMIT;
            end
            teq_pkg::S_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = teq_pkg::S_COMMIT;
            end
            teq_pkg::S_COMMIT: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = teq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = teq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= teq_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // a new result never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // only inserts go through the due tick stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == teq_pkg::S_SUM) |-> status.is_insert)
        else $error("tick transaction in due tick stage");

    // every accepted transaction starts in the multiply stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == teq_pkg::S_MUL))
        else $error("accepted transaction not dispatched");

endmodule

`default_nettype wire

/* rtl/teq_datapath.sv */
// teq_datapath: due tick arithmetic, sorted cell array and result register
// uses teq_pkg; controlled by teq_ctrl through cmd_t, reports status_t
`default_nettype none

module teq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  teq_pkg::cmd_t                    cmd,
    output teq_pkg::status_t                 status,
    input  wire                              cfg_wr_en,
    input  wire [teq_pkg::RATE_W-1:0]        cfg_wr_data,
    input  wire                              s_mode,
    input  wire [teq_pkg::TICK_W-1:0]        s_now_tick,
    input  wire [teq_pkg::DELAY_W-1:0]       s_start_delay,
    input  wire [teq_pkg::PORT_ID_W-1:0]     s_event_id,
    output logic                             m_due_valid,
    output logic [teq_pkg::PORT_ID_W-1:0]    m_due_id,
    output logic                             m_insert_rejected,
    output logic [teq_pkg::OCC_W-1:0]        m_occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [teq_pkg::RATE_W-1:0]   rate_reg;
    logic                         mode_reg;
    logic [teq_pkg::TICK_W-1:0]   now_reg;
    logic [teq_pkg::DELAY_W-1:0]  delay_reg;
    logic [ID_WIDTH-1:0]          id_in_reg;
    logic [teq_pkg::PROD_W-1:0]   prod_reg;
    logic [teq_pkg::TICK_W-1:0]   due_new_reg;
    logic [CNT_W-1:0]             count_reg, count_next;

    logic [teq_pkg::TICK_W-1:0]   due_reg [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]          id_reg  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]       le;

    logic                         due_valid_reg;
    logic [teq_pkg::PORT_ID_W-1:0] due_id_reg;
    logic                         rejected_reg;

    logic [31:0]                  id_in_ext;
    logic [31:0]                  id_out_ext;
    logic [31:0]                  occ_ext;
    logic [teq_pkg::TICKS_W:0]    sum_wide;
    logic                         full, head_due, do_insert, do_pop;

    assign status.is_insert = (mode_reg == teq_pkg::MODE_INSERT);

    assign id_in_ext  = 32'(s_event_id);
    assign id_out_ext = 32'(id_reg[0]);
    assign occ_ext    = 32'(count_reg);

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_due  = (count_reg != '0) && (due_reg[0] <= now_reg);
    assign do_insert = cmd.commit && status.is_insert && !full;
    assign do_pop    = cmd.commit && !status.is_insert && head_due;

    assign sum_wide = (teq_pkg::TICKS_W + 1)'(now_reg)
                    + (teq_pkg::TICKS_W + 1)'(prod_reg[teq_pkg::PROD_W-1:teq_pkg::FRAC_W]);

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= teq_pkg::RATE_RESET;
        end else if (cfg_wr_en) begin
            rate_reg <= cfg_wr_data;
        end
    end

    // transaction capture and due tick arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_mode;
            now_reg   <= s_now_tick;
            delay_reg <= s_start_delay;
            id_in_reg <= id_in_ext[ID_WIDTH-1:0];
        end
        if (cmd.mul_en) begin
            prod_reg <= teq_pkg::PROD_W'(delay_reg) * teq_pkg::PROD_W'(rate_reg);
        end
        if (cmd.sum_en) begin
            if (sum_wide[teq_pkg::TICKS_W:teq_pkg::TICK_W] != '0) begin
                due_new_reg <= '1;
            end else begin
                due_new_reg <= sum_wide[teq_pkg::TICK_W-1:0];
            end
        end
    end

    // sorted cells: each compares itself against the new due tick
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            assign le[gi] = (CNT_W'(gi) < count_reg) && (due_reg[gi] <= due_new_reg);

            if (gi == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (do_insert && !le[gi]) begin
                        due_reg[gi] <= due_new_reg;
                        id_reg[gi]  <= id_in_reg;
                    end else if (do_pop && (QUEUE_DEPTH > 1)) begin
                        due_reg[gi] <= due_reg[gi+1];
                        id_reg[gi]  <= id_reg[gi+1];
                    end
                end
            end else if (gi == QUEUE_DEPTH - 1) begin : g_last
                always_ff @(posedge aclk) begin
                    if (do_insert && !le[gi]) begin
                        due_reg[gi] <= le[gi-1] ? due_new_reg : due_reg[gi-1];
                        id_reg[gi]  <= le[gi-1] ? id_in_reg   : id_reg[gi-1];
                    end
                end
            end else begin : g_mid
                always_ff @(posedge aclk) begin
                    if (do_insert && !le[gi]) begin
                        due_reg[gi] <= le[gi-1] ? due_new_reg : due_reg[gi-1];
                        id_reg[gi]  <= le[gi-1] ? id_in_reg   : id_reg[gi-1];
                    end else if (do_pop) begin
                        due_reg[gi] <= due_reg[gi+1];
                        id_reg[gi]  <= id_reg[gi+1];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            due_valid_reg <= do_pop;
            due_id_reg    <= do_pop ? id_out_ext[teq_pkg::PORT_ID_W-1:0] : '0;
            rejected_reg  <= status.is_insert && full;
        end
    end

    assign m_due_valid       = due_valid_reg;
    assign m_due_id          = due_id_reg;
    assign m_insert_rejected = rejected_reg;
    assign m_occupancy       = occ_ext[teq_pkg::OCC_W-1:0];

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("event count above queue depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && status.is_insert && full) |=> (rejected_reg && !due_valid_reg))
        else $error("full insert not flagged");

endmodule

`default_nettype wire

/* rtl/timed_event_queue.sv */
// timed_event_queue: top level of the time ordered event queue
// depends on teq_pkg, teq_ctrl and teq_datapath
`default_nettype none

// Time ordered event queue. An insert transaction (s_mode 0) converts its
// start delay, unsigned q16.16 seconds, into ticks by multiplying with the
// control_rate register and dropping the 16 fraction bits, adds s_now_tick
// and saturates at the all-ones tick. The event is placed behind every held
// event with an equal or earlier due tick, so events due together leave in
// arrival order. When all QUEUE_DEPTH cells are taken the insert is dropped
// and m_insert_rejected is set. A tick transaction (s_mode 1) pops the head
// event if its due tick is at or before s_now_tick and returns its id with
// m_due_valid set. Every transaction produces exactly one result, which also
// reports the number of held events on m_occupancy (low 5 bits).
// Steps: an insert goes from accept to result through capture, the 32x20
// multiply stage, the saturating add stage and the cell array update; a tick
// skips the add stage. One transaction is in flight at a time, so the next
// transaction is accepted the cycle after the result is loaded, even while
// that result still waits for m_ready. The user must write control_rate
// through cfg_wr_en/cfg_wr_data only while the queue is idle; the block does
// not enforce this. It resets to 4410. Queue cells need no clearing after
// reset: only cells below the held count are ever compared or popped.

module timed_event_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // configuration
    input  wire                              cfg_wr_en,
    input  wire [teq_pkg::RATE_W-1:0]        cfg_wr_data,
    // input transactions
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_mode,
    input  wire [teq_pkg::TICK_W-1:0]        s_now_tick,
    input  wire [teq_pkg::DELAY_W-1:0]       s_start_delay,
    input  wire [teq_pkg::PORT_ID_W-1:0]     s_event_id,
    // result transactions
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_due_valid,
    output logic [teq_pkg::PORT_ID_W-1:0]    m_due_id,
    output logic                             m_insert_rejected,
    output logic [teq_pkg::OCC_W-1:0]        m_occupancy
);

    teq_pkg::cmd_t    cmd;
    teq_pkg::status_t status;

    // sequencing: capture, multiply, add, commit with output handshake
    teq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, sorted cell array and result register
    teq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_mode            (s_mode),
        .s_now_tick        (s_now_tick),
        .s_start_delay     (s_start_delay),
        .s_event_id        (s_event_id),
        .m_due_valid       (m_due_valid),
        .m_due_id          (m_due_id),
        .m_insert_rejected (m_insert_rejected),
        .m_occupancy       (m_occupancy)
    );

endmodule

`default_nettype wire

/* test/tb_timed_event_queue.sv */
// tb_timed_event_queue: self-checking testbench for the timed event queue
// holds its own time-ordered store as predictor and checks every result transaction
// depends on teq_pkg and timed_event_queue from rtl

module tb_timed_event_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import teq_pkg::*;

    localparam int QUEUE_DEPTH     = 16;
    localparam int ID_WIDTH        = 8;
    localparam int CLK_PERIOD      = 10;
    localparam int STALL_LIMIT     = 2000;   // cycles with no transaction on either side
    localparam int LONG_HOLD       = 300;    // receiver hold-off for the pressure test
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASE_COUNT     = 6;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // one result transaction, field order as on the m_ ports
    typedef struct packed {
        logic                 due_valid;
        logic [PORT_ID_W-1:0] due_id;
        logic                 insert_rejected;
        logic [OCC_W-1:0]     occupancy;
    } queue_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [RATE_W-1:0]    cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_mode;
    logic [TICK_W-1:0]    s_now_tick;
    logic [DELAY_W-1:0]   s_start_delay;
    logic [PORT_ID_W-1:0] s_event_id;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_due_valid;
    logic [PORT_ID_W-1:0] m_due_id;
    logic                 m_insert_rejected;
    logic [OCC_W-1:0]     m_occupancy;

    // shadow of the event store, kept sorted by due tick
    logic [TICK_W-1:0]    sched_due [QUEUE_DEPTH];
    logic [PORT_ID_W-1:0] sched_id [QUEUE_DEPTH];
    int                   sched_count;
    logic [RATE_W-1:0]    rate_shadow;
    queue_result_t        pending_results[$];

    // idling knobs of the sender (tx_gap_max) and the receiver (rx_stall_max, rx_hold_req)
    int tx_gap_max;
    int rx_stall_max;
    int rx_hold_req;

    int err_count;
    int n_inserts;
    int n_rejects;
    int n_ticks;
    int n_pops;
    int n_rates;

    timed_event_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_now_tick       (s_now_tick),
        .s_start_delay    (s_start_delay),
        .s_event_id       (s_event_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_due_valid      (m_due_valid),
        .m_due_id         (m_due_id),
        .m_insert_rejected(m_insert_rejected),
        .m_occupancy      (m_occupancy)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // delay in q16.16 seconds times rate, fraction dropped, added to now, clamped
    function automatic logic [TICK_W-1:0] due_tick_for(input logic [TICK_W-1:0] now,
                                                       input logic [DELAY_W-1:0] delay,
                                                       input logic [RATE_W-1:0] rate);
        logic [PROD_W-1:0]  product;
        logic [TICKS_W-1:0] ticks;
        logic [TICKS_W:0]   total;
        product = PROD_W'(delay) * PROD_W'(rate);
        ticks   = product[PROD_W-1:FRAC_W];
        total   = (TICKS_W + 1)'(ticks) + (TICKS_W + 1)'(now);
        if (total > (TICKS_W + 1)'(TICK_MAX))
            return TICK_MAX;
        return total[TICK_W-1:0];
    endfunction

    // applies one accepted transaction to the shadow store, returns the expected result
    function automatic queue_result_t schedule_step(input logic mode,
                                                    input logic [TICK_W-1:0] now,
                                                    input logic [DELAY_W-1:0] delay,
                                                    input logic [PORT_ID_W-1:0] id);
        queue_result_t     res;
        logic [TICK_W-1:0] due;
        int                pos;
        res = '0;
        if (mode == MODE_INSERT) begin
            if (sched_count >= QUEUE_DEPTH) begin
                res.insert_rejected = 1'b1;
            end else begin
                due = due_tick_for(now, delay, rate_shadow);
                pos = 0;
                // equal due ticks keep arrival order
                while (pos < sched_count && sched_due[pos] <= due)
                    pos++;
                for (int k = sched_count; k > pos; k--) begin
                    sched_due[k] = sched_due[k-1];
                    sched_id[k]  = sched_id[k-1];
                end
                sched_due[pos] = due;
                sched_id[pos]  = id;
                sched_count++;
            end
        end else if (sched_count > 0 && sched_due[0] <= now) begin
            res.due_valid = 1'b1;
            res.due_id    = sched_id[0];
            for (int k = 1; k < sched_count; k++) begin
                sched_due[k-1] = sched_due[k];
                sched_id[k-1]  = sched_id[k];
            end
            sched_count--;
        end
        res.occupancy = sched_count[OCC_W-1:0];
        return res;
    endfunction

    // predicts on every input transaction and checks every result transaction
    always @(posedge aclk) begin : scoreboard
        queue_result_t want;
        queue_result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = schedule_step(s_mode, s_now_tick, s_start_delay, s_event_id);
                pending_results.push_back(want);
                if (s_mode == MODE_INSERT) n_inserts++;
                else n_ticks++;
                if (want.insert_rejected) n_rejects++;
                if (want.due_valid) n_pops++;
            end
            if (m_valid && m_ready) begin
                got = {m_due_valid, m_due_id, m_insert_rejected, m_occupancy};
                if (pending_results.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.due_valid !== want.due_valid) begin
                        $error("due_valid: expected %0d, got %0d", want.due_valid, got.due_valid);
                        err_count++;
                    end
                    if (got.due_id !== want.due_id) begin
                        $error("due_id: expected %0d, got %0d", want.due_id, got.due_id);
                        err_count++;
                    end
                    if (got.insert_rejected !== want.insert_rejected) begin
                        $error("insert_rejected: expected %0d, got %0d",
                               want.insert_rejected, got.insert_rejected);
                        err_count++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                        err_count++;
                    end
                end
            end
        end
    end

    // result side: random stall per transaction, or one long hold-off on request
    initial begin : result_sink
        int hold;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                hold = $urandom_range(0, rx_stall_max);
            end
            if (hold > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (hold - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // ends the run when no transaction moves on either side for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
        $display("tb: failure");
        $finish;
    end

    // offers one transaction after a random gap and returns at its accepting edge
    task automatic send_item(input logic mode, input logic [TICK_W-1:0] now,
                             input logic [DELAY_W-1:0] delay,
                             input logic [PORT_ID_W-1:0] id);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_now_tick    <= now;
        s_start_delay <= delay;
        s_event_id    <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // sender goes quiet until every expected result has been taken
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // control rate write, only with the queue idle
    task automatic set_rate(input logic [RATE_W-1:0] rate);
        wait_drained();
        repeat (6) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rate;
        rate_shadow = rate;
        n_rates++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ticks on an empty store, at both ends of the tick range
    task automatic test_empty_ticks();
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_TICK, TICK_MAX, '1, '1);
    endtask

    // reset rate: saturated due tick, tick just short of due, delay zero due at once
    task automatic test_due_tick_edges();
        send_item(MODE_INSERT, TICK_MAX - 1000, '1, 8'hA5);
        send_item(MODE_TICK, TICK_MAX - 1, '0, '0);
        send_item(MODE_TICK, TICK_MAX, '0, '0);
        send_item(MODE_INSERT, 32'd5000, '0, 8'h00);
        send_item(MODE_TICK, 32'd5000, '0, '0);
    endtask

    // zero rate makes every event due at its now tick; fill, then one insert too many
    task automatic test_full_store();
        logic [PORT_ID_W-1:0] id;
        set_rate('0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            id = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : PORT_ID_W'($urandom_range(0, 255));
            send_item(MODE_INSERT, 32'd777, $urandom, id);
        end
        send_item(MODE_INSERT, 32'd0, '0, 8'h3C);
    endtask

    // long receiver hold-off with back-to-back transactions; the ticks drain the
    // full store in arrival order
    task automatic test_backpressure();
        tx_gap_max  = 0;
        rx_hold_req = LONG_HOLD;
        for (int i = 0; i < 20; i++)
            send_item((i < QUEUE_DEPTH) ? MODE_TICK : MODE_INSERT, 32'd777, $urandom,
                      PORT_ID_W'($urandom_range(0, 255)));
        wait_drained();
        tx_gap_max = 5;
    endtask

    // random phases over several control rates; ticks advance a running clock,
    // delays mostly map to a few dozen ticks so events fall due while others wait
    task automatic test_random_phases();
        logic [RATE_W-1:0]    rates [PHASE_COUNT];
        int                   insert_pct [PHASE_COUNT];
        logic [TICK_W-1:0]    now_cur;
        logic [TICK_W-1:0]    now;
        logic [DELAY_W-1:0]   delay;
        logic                 mode;
        int                   target;
        rates[0] = 20'd1;
        rates[1] = '1;
        rates[2] = RATE_RESET;
        rates[3] = RATE_W'($urandom_range(2, 20'hFFFFE));
        rates[4] = 20'd16;
        rates[5] = RATE_W'($urandom_range(1, 20'hFFFFF));
        insert_pct = '{60, 40, 70, 30, 65, 50};
        now_cur = 32'd1000;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_rate(rates[p]);
            // phase two runs without any idling on either side
            tx_gap_max   = (p == 2) ? 0 : 5;
            rx_stall_max = (p == 2) ? 0 : 5;
            // phase four crosses the top of the tick range
            if (p == 4)
                now_cur = TICK_MAX - 600;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                mode = ($urandom_range(0, 99) < insert_pct[p]) ? MODE_INSERT : MODE_TICK;
                if ($urandom_range(0, 9) == 0) begin
                    now = $urandom;
                end else begin
                    now_cur = now_cur + $urandom_range(0, 8);
                    now = now_cur;
                end
                target = $urandom_range(0, 48);
                if ($urandom_range(0, 9) == 0 || rate_shadow == 0)
                    delay = $urandom;
                else
                    delay = DELAY_W'(((target << FRAC_W) / 32'(rate_shadow))
                                     + $urandom_range(0, 255));
                send_item(mode, now, delay, PORT_ID_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_mode        = MODE_INSERT;
        s_now_tick    = '0;
        s_start_delay = '0;
        s_event_id    = '0;
        sched_count   = 0;
        rate_shadow   = RATE_RESET;
        tx_gap_max    = 5;
        rx_stall_max  = 5;
        rx_hold_req   = 0;
        err_count     = 0;
        n_inserts     = 0;
        n_rejects     = 0;
        n_ticks       = 0;
        n_pops        = 0;
        n_rates       = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_ticks();
        test_due_tick_edges();
        test_full_store();
        test_backpressure();
        test_random_phases();

        wait_drained();
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end
        $display("run covered %0d inserts (%0d rejected on a full store) and %0d ticks",
                 n_inserts, n_rejects, n_ticks);
        $display("%0d events popped, %0d control rate writes, %0d mismatches",
                 n_pops, n_rates, err_count);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
